// ===== rtl/core/apa_pkg.sv =====
// ----------------------------------------------------------------------------
// Arena pool allocator package
// Shared sizes, codes and the descriptor layout of the pool allocator.
// ----------------------------------------------------------------------------
package apa_pkg;

  // Table size and the widths that follow from it.
  localparam int POOL_COUNT = 16;
  localparam int POOL_IDX_W = $clog2(POOL_COUNT);
  localparam int LINK_W     = $clog2(POOL_COUNT + 1);
  localparam int ADDR_W     = 32;

  // Field widths of the request and the result.
  localparam int FUNC_W     = 2;
  localparam int ID_W       = 4;
  localparam int SIZE_W     = 24;
  localparam int IN_ADDR_W  = 32;
  localparam int STATUS_W   = 3;
  localparam int OUT_ADDR_W = 32;

  // Link value that marks the end of the free list.
  localparam logic [LINK_W-1:0] NONE_IDX = LINK_W'(POOL_COUNT);

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RESET = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_GET   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_POOL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  typedef logic [ADDR_W-1:0] addr_t;

  // One pool descriptor as held in the descriptor memory.
  typedef struct packed {
    addr_t             base;
    logic [SIZE_W-1:0] length;
    addr_t             bump;
  } desc_t;

  localparam int DESC_W = $bits(desc_t);

  // Latched request.
  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [ID_W-1:0]      pool_id;
    logic [SIZE_W-1:0]    req_size;
    logic [IN_ADDR_W-1:0] base_addr;
  } req_t;

endpackage

// ===== rtl/core/apa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module apa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/arena_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Arena pool allocator
// Free-list allocator of pool descriptors with a bump pointer per pool.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------
//  input     start, busy               in_func, in_pool_id, in_req_size,
//                                      in_base_addr
//  result    out_valid (one cycle)     out_status, out_granted_pool,
//                                      out_granted_addr
//
// Each item has an accept step and an execute step: the accept edge reads the
// descriptor memory; the edge ending execute computes, writes the descriptor
// back and registers the result. busy is high during execute, so no new item is
// accepted then; the result strobe lies in the cycle after the write-back.
// Reset is synchronous; it fills the free list, clears valid bits and control.
// The result is shown for one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module arena_pool_allocator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [apa_pkg::FUNC_W-1:0]      in_func,
  input  logic [apa_pkg::ID_W-1:0]        in_pool_id,
  input  logic [apa_pkg::SIZE_W-1:0]      in_req_size,
  input  logic [apa_pkg::IN_ADDR_W-1:0]   in_base_addr,
  output logic                            out_valid,
  output logic [apa_pkg::STATUS_W-1:0]    out_status,
  output logic [apa_pkg::ID_W-1:0]        out_granted_pool,
  output logic [apa_pkg::OUT_ADDR_W-1:0]  out_granted_addr
);

  import apa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  req_t                  req_r;
  logic [LINK_W-1:0]     free_head_r, free_head_nxt;
  logic [LINK_W-1:0]     link_r [POOL_COUNT];
  logic [POOL_COUNT-1:0] pool_valid_r, pool_valid_nxt;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [ID_W-1:0]       out_pool_r, out_pool_nxt;
  logic [OUT_ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic                  accept;
  logic [POOL_IDX_W-1:0] rd_idx;
  logic [POOL_IDX_W-1:0] head_idx;
  logic [POOL_IDX_W-1:0] req_idx;
  logic [POOL_IDX_W-1:0] wr_idx;
  logic                  ram_we;
  desc_t                 rd_desc;
  desc_t                 wr_desc;

  logic                  id_ok;
  logic                  hit;
  addr_t                 req_base;
  addr_t                 used;
  logic [ADDR_W:0]       need;
  logic                  ovf;
  logic                  link_we;
  logic [POOL_IDX_W-1:0] link_idx;
  logic [LINK_W-1:0]     link_val;

  assign accept   = start && (state_r == S_IDLE);
  assign head_idx = free_head_r[POOL_IDX_W-1:0];
  assign req_idx  = POOL_IDX_W'(req_r.pool_id);
  assign rd_idx   = (in_func == FN_ALLOC) ? head_idx : POOL_IDX_W'(in_pool_id);

  // Descriptor memory: base, length and bump pointer of each pool.
  apa_ram #(
    .WIDTH (DESC_W),
    .DEPTH (POOL_COUNT)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (wr_desc),
    .raddr (rd_idx),
    .rdata (rd_desc)
  );

  // Request checks and bump arithmetic on the descriptor just read.
  assign id_ok    = (32'(req_r.pool_id) < 32'(POOL_COUNT));
  assign hit      = id_ok && pool_valid_r[req_idx];
  assign req_base = ADDR_W'(req_r.base_addr);
  assign used     = rd_desc.bump - rd_desc.base;
  assign need     = {1'b0, used} + (ADDR_W + 1)'(req_r.req_size);
  assign ovf      = need > (ADDR_W + 1)'(rd_desc.length);

  // Operation decode in the execute cycle.
  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    pool_valid_nxt = pool_valid_r;
    ram_we         = 1'b0;
    wr_idx         = req_idx;
    wr_desc        = rd_desc;
    link_we        = 1'b0;
    link_idx       = req_idx;
    link_val       = free_head_r;
    out_status_nxt = ST_OK;
    out_pool_nxt   = '0;
    out_addr_nxt   = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (req_r.func == FN_ALLOC) begin
          if (free_head_r >= NONE_IDX) begin
            out_status_nxt = ST_NO_POOL;
          end else if (req_r.req_size == '0) begin
            out_status_nxt = ST_ZERO;
          end else begin
            ram_we                   = 1'b1;
            wr_idx                   = head_idx;
            wr_desc.base             = req_base;
            wr_desc.length           = req_r.req_size;
            wr_desc.bump             = req_base;
            pool_valid_nxt[head_idx] = 1'b1;
            free_head_nxt            = link_r[head_idx];
            link_we                  = 1'b1;
            link_idx                 = head_idx;
            link_val                 = NONE_IDX;
            out_pool_nxt             = ID_W'(head_idx);
            out_addr_nxt             = OUT_ADDR_W'(req_base);
          end
        end else if (!hit) begin
          out_status_nxt = ST_INVALID;
        end else begin
          case (req_r.func)
            FN_RESET: begin
              ram_we       = 1'b1;
              wr_desc.bump = rd_desc.base;
            end
            FN_FREE: begin
              // Descriptor fields are dead once the valid bit drops.
              pool_valid_nxt[req_idx] = 1'b0;
              link_we                 = 1'b1;
              link_val                = free_head_r;
              free_head_nxt           = LINK_W'(req_idx);
            end
            default: begin
              if (ovf) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                ram_we       = 1'b1;
                wr_desc.bump = rd_desc.bump + ADDR_W'(req_r.req_size);
                out_addr_nxt = OUT_ADDR_W'(rd_desc.bump);
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, free list and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= '0;
      pool_valid_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < POOL_COUNT; i++) begin
        link_r[i] <= LINK_W'(i + 1);
      end
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      pool_valid_r <= pool_valid_nxt;
      out_valid_r  <= (state_r == S_EXEC);
      if (link_we) begin
        link_r[link_idx] <= link_val;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.func      <= in_func;
      req_r.pool_id   <= in_pool_id;
      req_r.req_size  <= in_req_size;
      req_r.base_addr <= in_base_addr;
    end
    if (state_r == S_EXEC) begin
      out_status_r <= out_status_nxt;
      out_pool_r   <= out_pool_nxt;
      out_addr_r   <= out_addr_nxt;
    end
  end

  assign busy             = (state_r == S_EXEC);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_pool = out_pool_r;
  assign out_granted_addr = out_addr_r;

  // An accepted item always enters the execute cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not enter execute");

  // A result strobe only follows an execute cycle.
  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EXEC))
    else $error("result strobe without execute");

  // The free-list head is a pool index or the end marker.
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= NONE_IDX)
    else $error("free-list head out of range");

  // A granted pool is marked valid.
  a_alloc_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && req_r.func == FN_ALLOC)
      |-> pool_valid_r[POOL_IDX_W'(out_granted_pool)])
    else $error("granted pool not marked valid");

endmodule
